@@ design/zscore_pulse_detector_defines.svh @@
// Assertion macros used by the checker.
`ifndef ZSCORE_PULSE_DETECTOR_DEFINES_SVH
`define ZSCORE_PULSE_DETECTOR_DEFINES_SVH
// An implication checked at every clock edge outside reset.
`define ZPD_ASSERT_IMPL(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// A next-cycle implication checked outside reset.
`define ZPD_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ design/zpd_pkg.sv @@
package zpd_pkg;
	localparam int unsigned WindowDefault = 1024;
	localparam int unsigned LagDefault = 10;
	localparam logic [11:0] GainReset = 12'd896;
	localparam logic [15:0] MinPulseReset = 16'd16;
	localparam logic [23:0] TimeoutReset = 24'd65535;
	localparam logic [1:0] RegGain = 2'd0;
	localparam logic [1:0] RegMinPulse = 2'd1;
	localparam logic [1:0] RegTimeout = 2'd2;
	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_WAIT, ST_EDGE, ST_SQMUL, ST_SQUARE,
		ST_ROOT, ST_TRIG, ST_WRITE, ST_CLEAR
	} state_t;
endpackage

@@ design/zscore_pulse_detector.sv @@
// Each accepted sample request passes through READ, WAIT, EDGE, SQMUL, SQUARE, ROOT,
// TRIG and WRITE before its result is valid (missing sample: result registered on
// acceptance). The 24-step bit-serial square root runs in ROOT on one adder/compare
// unit; a request is taken only in IDLE, and a result that waits holds off the next one.
// Reset: asynchronous, active low; after release a clearing pass zeroes every entry
// of the history memories before the first sample request is accepted.
module zscore_pulse_detector import zpd_pkg::*; #(
	parameter int unsigned WINDOW = WindowDefault,
	parameter int unsigned LAG = LagDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_value
	input  logic        s_tuser,   // [0] sample_missing
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] pulse_found, [16:1] pulse_peak, [32:17] echo_value, [56:33] mean_level,
	// [88:57] variance_level, [112:89] deviation_level, [140:113] trigger_level,
	// [143:141] zero
	output logic [143:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(WINDOW);
	localparam int WSW = 16 + $clog2(WINDOW + 1);
	localparam int SSW = 32 + $clog2(WINDOW + 1);

	// Configuration registers.
	logic [11:0] gain_q;
	logic [15:0] min_pulse_q;
	logic [23:0] timeout_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
			min_pulse_q <= MinPulseReset;
			timeout_q <= TimeoutReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				RegGain:     gain_q <= pwdata[11:0];
				RegMinPulse: min_pulse_q <= pwdata[15:0];
				RegTimeout:  timeout_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			RegGain:     prdata = {20'd0, gain_q};
			RegMinPulse: prdata = {16'd0, min_pulse_q};
			RegTimeout:  prdata = {8'd0, timeout_q};
			default:     prdata = '0;
		endcase
	end

	// History memories, one entry per window slot. Each is read at one address.
	logic [23:0] mean_mem [WINDOW];
	logic [23:0] dev_mem [WINDOW];
	logic [15:0] samp_mem [WINDOW];
	logic [31:0] sq_mem [WINDOW];
	logic [23:0] lag_mean_q, lag_dev_q;
	logic [15:0] old_samp_q;
	logic [31:0] old_sq_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic mem_we;
	logic [23:0] mean_wd, dev_wd;
	logic [15:0] samp_wd;
	logic [31:0] sq_wd;

	state_t state_q, state_d;
	logic [AW-1:0] wp_q, clr_q;
	logic [4:0] cnt_q;
	logic [15:0] samp_q;
	logic [WSW-1:0] wsum_q;
	logic [SSW-1:0] ssum_q;
	logic tracking_q;
	logic [15:0] peak_q, plen_q;
	logic [23:0] since_q;
	logic found_q;
	logic [15:0] peak_out_q;
	logic [23:0] mean_q;
	logic [31:0] var_q;
	logic [47:0] rem_q;
	logic [23:0] root_q;
	logic [47:0] rad_q;
	logic [47:0] prod_q;

	// Shared multiplier operands; the square is registered in prod_q, the other products are not.
	logic [23:0] mul_a;
	logic [23:0] mul_b;
	logic [47:0] mul_p;
	assign mul_p = {24'd0, mul_a} * {24'd0, mul_b};

	logic [AW-1:0] lag_idx;
	assign lag_idx = wp_q - AW'(LAG % WINDOW);

	assign rd_addr = (state_q == ST_IDLE) ? lag_idx : wp_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mean_mem[wr_addr] <= mean_wd;
			dev_mem[wr_addr] <= dev_wd;
			samp_mem[wr_addr] <= samp_wd;
			sq_mem[wr_addr] <= sq_wd;
		end
		lag_mean_q <= mean_mem[rd_addr];
		lag_dev_q <= dev_mem[rd_addr];
		old_samp_q <= samp_mem[rd_addr];
		old_sq_q <= sq_mem[rd_addr];
	end

	// Lagged entries are held while the old sample and square are read.
	logic [23:0] hold_mean_q, hold_dev_q;

	logic s_acc, m_acc;
	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	// Edge compare, in Q.16.
	logic [39:0] rhs;
	logic [31:0] lhs;
	assign rhs = {8'd0, hold_mean_q, 8'd0} + 40'(mul_p);
	assign lhs = {samp_q, 16'd0};

	// New window sum and mean.
	logic [WSW-1:0] wsum_new;
	assign wsum_new = wsum_q - WSW'(old_samp_q) + WSW'(samp_q);
	logic [WSW+7:0] mean_full;
	assign mean_full = {wsum_new, 8'd0} >> AW;
	logic [23:0] mean_new;
	assign mean_new = (mean_full > (WSW+8)'(24'hFFFFFF)) ? 24'hFFFFFF : mean_full[23:0];

	// The sample may sit a full 24 bits away from the mean in Q.8.
	logic [24:0] dsgn;
	assign dsgn = {1'b0, samp_q, 8'd0} - {1'b0, mean_q};
	logic [23:0] absd;
	assign absd = dsgn[24] ? 24'(-dsgn) : dsgn[23:0];

	logic [SSW-1:0] ssum_new;
	assign ssum_new = ssum_q - SSW'(old_sq_q) + SSW'(sq_wd);

	logic [SSW-1:0] var_full;
	assign var_full = ssum_new >> AW;

	// Root step.
	logic [49:0] trial;
	logic [49:0] rem_sh;
	assign rem_sh = {rem_q, rad_q[47:46]};
	assign trial = {rem_sh} - {24'd0, root_q, 2'b01};

	logic [28:0] trig_sum;
	assign trig_sum = {5'd0, mean_q} + mul_p[36:8];

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		mem_we = 1'b0;
		wr_addr = wp_q;
		mean_wd = mean_q;
		dev_wd = root_q;
		samp_wd = samp_q;
		sq_wd = prod_q[47:16];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				wr_addr = clr_q;
				mean_wd = '0;
				dev_wd = '0;
				samp_wd = '0;
				sq_wd = '0;
				if (clr_q == AW'(WINDOW - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: if (s_acc && !s_tuser) state_d = ST_READ;
			ST_READ: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_EDGE;
			ST_EDGE: begin
				mul_a = {12'd0, gain_q};
				mul_b = hold_dev_q;
				state_d = ST_SQMUL;
			end
			ST_SQMUL: begin
				mul_a = absd;
				mul_b = absd;
				state_d = ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_ROOT;
			ST_ROOT: if (cnt_q == 5'd23) state_d = ST_TRIG;
			ST_TRIG: begin
				mul_a = {12'd0, gain_q};
				mul_b = root_q;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			wp_q <= '0;
			wsum_q <= '0;
			ssum_q <= '0;
			tracking_q <= 1'b0;
			peak_q <= '0;
			plen_q <= '0;
			since_q <= '0;
			m_tvalid <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (m_acc) m_tvalid <= 1'b0;
			if (s_acc && s_tuser) begin
				m_tvalid <= 1'b1;
				m_tdata <= '0;
			end
			if (s_acc) samp_q <= s_tdata;
			if (state_q == ST_READ) begin
				hold_mean_q <= lag_mean_q;
				hold_dev_q <= lag_dev_q;
			end
			if (state_q == ST_EDGE) begin
				found_q <= 1'b0;
				peak_out_q <= '0;
				if (tracking_q) begin
					if (40'(lhs) < rhs) begin
						if (plen_q > min_pulse_q) begin
							found_q <= 1'b1;
							peak_out_q <= peak_q;
							since_q <= '0;
						end else begin
							since_q <= (since_q == 24'hFFFFFF) ? since_q : since_q + 1'b1;
						end
						tracking_q <= 1'b0;
						peak_q <= '0;
						plen_q <= '0;
					end else begin
						since_q <= (since_q == 24'hFFFFFF) ? since_q : since_q + 1'b1;
						if (samp_q > peak_q) peak_q <= samp_q;
						if (plen_q != 16'hFFFF) plen_q <= plen_q + 1'b1;
					end
				end else begin
					since_q <= (since_q == 24'hFFFFFF) ? since_q : since_q + 1'b1;
					if (40'(lhs) > rhs) begin
						tracking_q <= 1'b1;
						peak_q <= samp_q;
						plen_q <= 16'd1;
					end
				end
				wsum_q <= wsum_new;
				mean_q <= mean_new;
			end
			if (state_q == ST_SQMUL) prod_q <= mul_p;
			if (state_q == ST_SQUARE) begin
				ssum_q <= ssum_new;
				var_q <= (var_full > SSW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : var_full[31:0];
				rad_q <= {((var_full > SSW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : var_full[31:0]),
					16'd0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
			end
			if (state_q == ST_ROOT) begin
				cnt_q <= cnt_q + 1'b1;
				rad_q <= {rad_q[45:0], 2'b00};
				if (!trial[49]) begin
					rem_q <= trial[47:0];
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q <= rem_sh[47:0];
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			if (state_q == ST_TRIG) begin
				m_tdata[0] <= found_q;
				m_tdata[16:1] <= peak_out_q;
				m_tdata[32:17] <= samp_q;
				m_tdata[56:33] <= mean_q;
				m_tdata[88:57] <= var_q;
				m_tdata[112:89] <= root_q;
				m_tdata[140:113] <= trig_sum[28] ? 28'hFFFFFFF : trig_sum[27:0];
				m_tdata[143:141] <= '0;
			end
			if (state_q == ST_WRITE) begin
				m_tvalid <= 1'b1;
				wp_q <= (32'(wp_q) + 1 >= WINDOW) ? '0 : wp_q + 1'b1;
				if (since_q > timeout_q) begin
					since_q <= '0;
					tracking_q <= 1'b0;
					plen_q <= '0;
					peak_q <= '0;
				end
			end
		end
	end
endmodule

@@ design/zpd_checker.sv @@
`include "zscore_pulse_detector_defines.svh"
module zpd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [143:0] m_tdata
);
	`ZPD_ASSERT_IMPL(a_busy, arst_n, m_tvalid, !s_tready, "request taken while result waits")
	`ZPD_ASSERT_NEXT(a_miss, arst_n, s_tvalid && s_tready && s_tuser,
		m_tvalid && m_tdata == '0, "missing sample result not zero")
	`ZPD_ASSERT_IMPL(a_peak, arst_n, m_tvalid && !m_tdata[0], m_tdata[16:1] == 16'd0,
		"peak without pulse")
	`ZPD_ASSERT_NEXT(a_hold, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"result changed while waiting")
endmodule
bind zscore_pulse_detector zpd_checker u_zpd_checker (.*);

@@ sim/tb_zscore_pulse_detector.sv @@
`timescale 1ns / 100ps

module tb_zscore_pulse_detector;
	import zpd_pkg::*;

	localparam int unsigned WIN = WindowDefault;
	localparam int unsigned LAGN = LagDefault;
	localparam logic [3:0] AddrGain = {RegGain, 2'b00};
	localparam logic [3:0] AddrMinPulse = {RegMinPulse, 2'b00};
	localparam logic [3:0] AddrTimeout = {RegTimeout, 2'b00};
	// Cycles with no request accepted anywhere before the run is declared hung.
	// This covers the clearing pass after reset plus the longest receiver stall.
	localparam int WatchdogLimit = 6000;
	// Settle time after the last result before a register write, and at the end.
	localparam int SettleCycles = 40;

	typedef struct packed {
		logic        found;
		logic [15:0] peak;
		logic [15:0] echo;
		logic [23:0] mean;
		logic [31:0] variance;
		logic [23:0] deviation;
		logic [27:0] trigger;
	} detect_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;   // [15:0] sample_value
	logic         s_tuser;   // [0] sample_missing
	logic         m_tvalid;
	logic         m_tready;
	// [0] pulse_found, [16:1] pulse_peak, [32:17] echo_value, [56:33] mean_level,
	// [88:57] variance_level, [112:89] deviation_level, [140:113] trigger_level
	logic [143:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	zscore_pulse_detector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: copies of the detector's history memories and running sums.
	logic [23:0] hist_mean [WIN];
	logic [23:0] hist_dev [WIN];
	logic [15:0] hist_sample [WIN];
	logic [31:0] hist_square [WIN];
	logic [25:0] sum_samples;
	logic [41:0] sum_squares;
	logic [9:0]  wr_ptr;
	logic        in_pulse;
	logic [15:0] pulse_max;
	logic [15:0] pulse_len;
	logic [23:0] quiet_count;
	logic [11:0] cfg_gain;
	logic [15:0] cfg_min_pulse;
	logic [23:0] cfg_timeout;

	detect_result_t expected_results[$];
	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int pulses_seen = 0;
	int idle_cycles = 0;
	bit sender_gaps = 0;
	bit receiver_stalls = 0;

	always #1 clk = ~clk;

	// Integer square root by trying each result bit from the top down.
	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] trial;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// Advances the predictor by one accepted sample request and returns the result.
	function automatic detect_result_t predict_detection(input logic [15:0] s,
			input logic missing);
		detect_result_t res;
		logic [9:0]  lag_ptr;
		logic [63:0] level_s, level_ref, mean_q, var_q, dev_q, trig_q, diff, sq;
		res = '0;
		if (missing)
			return res;
		if (quiet_count != 24'hFFFFFF)
			quiet_count = quiet_count + 1;
		lag_ptr = wr_ptr - 10'(LAGN);
		level_s = 64'(s) << 16;
		level_ref = (64'(hist_mean[lag_ptr]) << 8) + 64'(cfg_gain) * 64'(hist_dev[lag_ptr]);
		if (in_pulse) begin
			if (level_s < level_ref) begin
				// Trailing edge: report only pulses strictly longer than the minimum.
				if (pulse_len > cfg_min_pulse) begin
					res.found = 1'b1;
					res.peak = pulse_max;
					quiet_count = 0;
				end
				in_pulse = 0;
				pulse_max = 0;
				pulse_len = 0;
			end else begin
				if (s > pulse_max)
					pulse_max = s;
				if (pulse_len != 16'hFFFF)
					pulse_len = pulse_len + 1;
			end
		end else if (level_s > level_ref) begin
			in_pulse = 1;
			pulse_max = s;
			pulse_len = 1;
		end
		sum_samples = sum_samples - hist_sample[wr_ptr] + s;
		hist_sample[wr_ptr] = s;
		mean_q = 64'(sum_samples) * 256 / WIN;
		if (mean_q > 64'hFFFFFF)
			mean_q = 64'hFFFFFF;
		hist_mean[wr_ptr] = mean_q[23:0];
		diff = (64'(s) << 8) >= mean_q ? (64'(s) << 8) - mean_q : mean_q - (64'(s) << 8);
		sq = (diff * diff) >> 16;
		sum_squares = sum_squares - hist_square[wr_ptr] + sq[31:0];
		hist_square[wr_ptr] = sq[31:0];
		var_q = 64'(sum_squares) / WIN;
		if (var_q > 64'hFFFFFFFF)
			var_q = 64'hFFFFFFFF;
		dev_q = int_root(var_q << 16);
		if (dev_q > 64'hFFFFFF)
			dev_q = 64'hFFFFFF;
		hist_dev[wr_ptr] = dev_q[23:0];
		trig_q = mean_q + ((64'(cfg_gain) * dev_q) >> 8);
		if (trig_q > 64'hFFFFFFF)
			trig_q = 64'hFFFFFFF;
		wr_ptr = wr_ptr + 1;
		// Silence timeout drops any pulse in progress.
		if (quiet_count > cfg_timeout) begin
			quiet_count = 0;
			in_pulse = 0;
			pulse_len = 0;
			pulse_max = 0;
		end
		res.echo = s;
		res.mean = mean_q[23:0];
		res.variance = var_q[31:0];
		res.deviation = dev_q[23:0];
		res.trigger = trig_q[27:0];
		return res;
	endfunction

	// Receiver readiness changes at the falling edge; with stalls enabled, ready is low with a chance of 17 in 100.
	always @(negedge clk) begin
		if (receiver_stalls)
			m_tready <= ($urandom_range(99) >= 17);
		else
			m_tready <= 1'b1;
	end

	// Result checker: each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		detect_result_t want;
		detect_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.peak = m_tdata[16:1];
			got.echo = m_tdata[32:17];
			got.mean = m_tdata[56:33];
			got.variance = m_tdata[88:57];
			got.deviation = m_tdata[112:89];
			got.trigger = m_tdata[140:113];
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			end else begin
				want = expected_results.pop_front();
				if (got.found)
					pulses_seen++;
				if (got.found !== want.found) begin
					errors++;
					$display("%0t: pulse_found expected %0d actual %0d", $time, want.found,
						got.found);
				end
				if (got.peak !== want.peak) begin
					errors++;
					$display("%0t: pulse_peak expected %0d actual %0d", $time, want.peak,
						got.peak);
				end
				if (got.echo !== want.echo) begin
					errors++;
					$display("%0t: echo_value expected %0d actual %0d", $time, want.echo,
						got.echo);
				end
				if (got.mean !== want.mean) begin
					errors++;
					$display("%0t: mean_level expected %0d actual %0d", $time, want.mean,
						got.mean);
				end
				if (got.variance !== want.variance) begin
					errors++;
					$display("%0t: variance_level expected %0d actual %0d", $time,
						want.variance, got.variance);
				end
				if (got.deviation !== want.deviation) begin
					errors++;
					$display("%0t: deviation_level expected %0d actual %0d", $time,
						want.deviation, got.deviation);
				end
				if (got.trigger !== want.trigger) begin
					errors++;
					$display("%0t: trigger_level expected %0d actual %0d", $time,
						want.trigger, got.trigger);
				end
			end
		end
	end

	// Watchdog: counts cycles in which no request is accepted on any port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sends one sample request. Valid stays high afterwards so back-to-back requests
	// keep it asserted; when gaps are enabled, a random gap lowers it first.
	task automatic send_sample(input logic [15:0] value, input logic missing);
		detect_result_t res;
		if (sender_gaps && $urandom_range(99) < 17) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = value;
		s_tuser = missing;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		res = predict_detection(value, missing);
		expected_results.push_back(res);
		samples_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Waits until every expected result has arrived, then lets the block settle.
	task automatic drain_results();
		stop_sending();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			AddrGain: cfg_gain = data[11:0];
			AddrMinPulse: cfg_min_pulse = data[15:0];
			AddrTimeout: cfg_timeout = data[23:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check(input logic [3:0] addr, input logic [31:0] want);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			errors++;
			$display("%0t: register %0d read expected %0d actual %0d", $time, addr, want,
				prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_config(input logic [11:0] gain, input logic [15:0] min_len,
			input logic [23:0] timeout);
		apb_write(AddrGain, 32'(gain));
		apb_write(AddrMinPulse, 32'(min_len));
		apb_write(AddrTimeout, 32'(timeout));
		apb_check(AddrGain, 32'(gain));
		apb_check(AddrMinPulse, 32'(min_len));
		apb_check(AddrTimeout, 32'(timeout));
	endtask

	// A quiet baseline with small noise followed by a raised pulse and a return.
	task automatic send_pulse_shape(input int base, input int height, input int len,
			input int tail);
		for (int i = 0; i < 6; i++)
			send_sample(16'(base + $urandom_range(3)), 1'b0);
		for (int i = 0; i < len; i++)
			send_sample(16'(height - $urandom_range(height / 8)), 1'b0);
		for (int i = 0; i < tail; i++)
			send_sample(16'(base + $urandom_range(3)), 1'b0);
	endtask

	task automatic test_reset_registers();
		apb_check(AddrGain, 32'(GainReset));
		apb_check(AddrMinPulse, 32'(MinPulseReset));
		apb_check(AddrTimeout, 32'(TimeoutReset));
	endtask

	// Field extremes and missing samples, including missing ones carrying data.
	task automatic test_field_extremes();
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd0, 1'b1);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'h5555, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h8000, 1'b0);
		drain_results();
	endtask

	// Pulses of both sides of the minimum length, plus gain and timeout extremes.
	// Registers change only once every request has produced its result.
	task automatic test_pulse_edges();
		set_config(12'd896, 16'd0, 24'hFFFFFF);
		send_pulse_shape(100, 60000, 1, 4);
		drain_results();
		set_config(12'd0, 16'd3, 24'hFFFFFF);
		send_pulse_shape(100, 40000, 3, 3);
		send_pulse_shape(100, 40000, 5, 3);
		drain_results();
		set_config(12'hFFF, 16'hFFFF, 24'd0);
		send_pulse_shape(50, 65535, 4, 4);
		drain_results();
		set_config(12'd256, 16'd2, 24'd6);
		send_pulse_shape(200, 30000, 12, 4);
		drain_results();
	endtask

	// Random pulse trains with noise, missing samples and register changes between
	// phases. One phase runs with no random sender gaps or receiver stalls.
	task automatic test_random_trains(input int total);
		int phase;
		int pick;
		int stop_at;
		logic [11:0] gain;
		logic [15:0] min_len;
		logic [23:0] timeout;
		phase = 0;
		while (samples_sent < total) begin
			drain_results();
			pick = $urandom_range(3);
			gain = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom_range(1536));
			pick = $urandom_range(3);
			min_len = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(12));
			pick = $urandom_range(3);
			timeout = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF : 24'($urandom_range(200));
			set_config(gain, min_len, timeout);
			sender_gaps = (phase != 2);
			receiver_stalls = (phase != 2);
			stop_at = samples_sent + 150;
			while (samples_sent < stop_at && samples_sent < total) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_pulse_shape($urandom_range(2000), $urandom_range(20000, 65535),
						$urandom_range(1, 20), $urandom_range(1, 8));
				end else if (pick < 85) begin
					send_sample(16'($urandom_range(65535)), 1'b0);
				end else begin
					send_sample(16'($urandom_range(65535)), 1'b1);
				end
				// Hold off once in a while until the pipeline is completely empty.
				if ($urandom_range(99) < 3) begin
					stop_sending();
					while (expected_results.size() != 0) @(posedge clk);
				end
			end
			phase++;
		end
		sender_gaps = 1;
		receiver_stalls = 1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < WIN; i++) begin
			hist_mean[i] = '0;
			hist_dev[i] = '0;
			hist_sample[i] = '0;
			hist_square[i] = '0;
		end
		sum_samples = '0;
		sum_squares = '0;
		wr_ptr = '0;
		in_pulse = 0;
		pulse_max = '0;
		pulse_len = '0;
		quiet_count = '0;
		cfg_gain = GainReset;
		cfg_min_pulse = MinPulseReset;
		cfg_timeout = TimeoutReset;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_registers();
		sender_gaps = 1;
		receiver_stalls = 1;
		test_field_extremes();
		test_pulse_edges();
		test_random_trains(1050);

		drain_results();
		$display("Sent %0d sample requests and checked %0d results, %0d with a pulse.",
			samples_sent, results_seen, pulses_seen);
		$display("Covered missing samples, field extremes, gain, minimum length and timeout extremes.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
